// ----- rtl/core/g2d_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package g2d_pkg;

  localparam logic [1:0] PH_CONTROL = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_NAME    = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  localparam logic [2:0] KIND_CONTROL = 3'd0;
  localparam logic [2:0] KIND_LENGTH  = 3'd1;
  localparam logic [2:0] KIND_NAME    = 3'd2;
  localparam logic [2:0] KIND_PAYLOAD = 3'd3;
  localparam logic [2:0] KIND_END     = 3'd4;
  localparam logic [2:0] KIND_REJECT  = 3'd5;

  localparam int BIT_BIG_ENDIAN = 1;
  localparam int BIT_COMPOUND   = 2;

  typedef struct packed {
    logic [7:0]  data_out;
    logic [2:0]  byte_kind;
    logic [2:0]  field_index;
    logic [3:0]  name_length;
    logic [23:0] payload_length;
    logic        is_compound;
    logic        packet_end;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/g2d_raw_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface g2d_raw_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/g2d_parsed_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface g2d_parsed_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_out;
  logic [2:0]  byte_kind;
  logic [2:0]  field_index;
  logic [3:0]  name_length;
  logic [23:0] payload_length;
  logic        is_compound;
  logic        packet_end;

  modport source (
    output valid, output data_out, output byte_kind, output field_index,
    output name_length, output payload_length, output is_compound,
    output packet_end, input ready
  );
  modport sink (
    input valid, input data_out, input byte_kind, input field_index,
    input name_length, input payload_length, input is_compound,
    input packet_end, output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/g2d_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module g2d_parser (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           accept,
  input  wire logic [7:0]     data_byte,
  output g2d_pkg::result_t    result
);

  logic [1:0]  phase, phase_next;
  logic [1:0]  len_left, len_left_next;
  logic [1:0]  len_idx, len_idx_next;
  logic [23:0] len_acc, len_acc_next;
  logic [3:0]  name_total, name_total_next;
  logic [3:0]  name_left, name_left_next;
  logic [23:0] pay_left, pay_left_next;
  logic        compound, compound_next;

  logic [2:0]  kind;
  logic [2:0]  idx;
  logic        pend;

  always_comb begin
    phase_next      = phase;
    len_left_next   = len_left;
    len_idx_next    = len_idx;
    len_acc_next    = len_acc;
    name_total_next = name_total;
    name_left_next  = name_left;
    pay_left_next   = pay_left;
    compound_next   = compound;
    kind            = g2d_pkg::KIND_CONTROL;
    idx             = 3'd0;
    pend            = 1'b0;

    unique case (phase)
      g2d_pkg::PH_CONTROL: begin
        if (data_byte == 8'd0) begin
          kind = g2d_pkg::KIND_END;
        end else if (data_byte[g2d_pkg::BIT_BIG_ENDIAN]) begin
          kind = g2d_pkg::KIND_REJECT;
        end else begin
          kind            = g2d_pkg::KIND_CONTROL;
          len_left_next   = data_byte[7:6];
          len_idx_next    = 2'd0;
          len_acc_next    = 24'd0;
          name_total_next = {1'b0, data_byte[5:3]} + 4'd1;
          compound_next   = data_byte[g2d_pkg::BIT_COMPOUND];
          pay_left_next   = 24'd0;
          if (data_byte[7:6] != 2'd0) begin
            phase_next = g2d_pkg::PH_LENGTH;
          end else begin
            name_left_next = {1'b0, data_byte[5:3]} + 4'd1;
            phase_next     = g2d_pkg::PH_NAME;
          end
        end
      end
      g2d_pkg::PH_LENGTH: begin
        kind = g2d_pkg::KIND_LENGTH;
        idx  = {1'b0, len_idx};
        unique case (len_idx)
          2'd0:    len_acc_next = len_acc | {16'd0, data_byte};
          2'd1:    len_acc_next = len_acc | {8'd0, data_byte, 8'd0};
          2'd2:    len_acc_next = len_acc | {data_byte, 16'd0};
          default: len_acc_next = len_acc;
        endcase
        len_idx_next  = len_idx + 2'd1;
        len_left_next = len_left - 2'd1;
        if (len_left == 2'd1) begin
          name_left_next = name_total;
          phase_next     = g2d_pkg::PH_NAME;
        end
      end
      g2d_pkg::PH_NAME: begin
        kind           = g2d_pkg::KIND_NAME;
        idx            = 3'(name_total - name_left);
        name_left_next = name_left - 4'd1;
        if (name_left == 4'd1) begin
          if (len_acc == 24'd0) begin
            pend       = 1'b1;
            phase_next = g2d_pkg::PH_CONTROL;
          end else begin
            pay_left_next = len_acc;
            phase_next    = g2d_pkg::PH_PAYLOAD;
          end
        end
      end
      default: begin
        kind          = g2d_pkg::KIND_PAYLOAD;
        pay_left_next = pay_left - 24'd1;
        if (pay_left == 24'd1) begin
          pend       = 1'b1;
          phase_next = g2d_pkg::PH_CONTROL;
        end
      end
    endcase
  end

  always_comb begin
    result.data_out       = data_byte;
    result.byte_kind      = kind;
    result.field_index    = idx;
    result.name_length    = name_total_next;
    result.payload_length = len_acc_next;
    result.is_compound    = compound_next;
    result.packet_end     = pend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= g2d_pkg::PH_CONTROL;
      len_left   <= 2'd0;
      len_idx    <= 2'd0;
      len_acc    <= 24'd0;
      name_total <= 4'd1;
      name_left  <= 4'd0;
      pay_left   <= 24'd0;
      compound   <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      len_left   <= len_left_next;
      len_idx    <= len_idx_next;
      len_acc    <= len_acc_next;
      name_total <= name_total_next;
      name_left  <= name_left_next;
      pay_left   <= pay_left_next;
      compound   <= compound_next;
    end
  end

  a_end_to_control: assert property (@(posedge clk) disable iff (rst)
    accept && pend |=> phase == g2d_pkg::PH_CONTROL)
    else $error("Packet end did not return the parser to the control phase.");

  a_name_total_nonzero: assert property (@(posedge clk) disable iff (rst)
    name_total != 4'd0 && name_total <= 4'd8)
    else $error("Name length left its range.");

  a_length_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == g2d_pkg::PH_LENGTH |-> len_left != 2'd0)
    else $error("Length phase entered with no length bytes left.");

  a_payload_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == g2d_pkg::PH_PAYLOAD |-> pay_left != 24'd0)
    else $error("Payload phase entered with no payload bytes left.");

  a_name_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == g2d_pkg::PH_NAME |-> name_left != 4'd0 && name_left <= name_total)
    else $error("Name phase count out of range.");

endmodule

`default_nettype wire

// ----- rtl/core/g2d_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module g2d_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire g2d_pkg::result_t   result,
  output logic                    space,
  g2d_parsed_if.source            parsed
);

  logic             full;
  g2d_pkg::result_t held;

  assign space = !full || parsed.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (parsed.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign parsed.valid          = full;
  assign parsed.data_out       = held.data_out;
  assign parsed.byte_kind      = held.byte_kind;
  assign parsed.field_index    = held.field_index;
  assign parsed.name_length    = held.name_length;
  assign parsed.payload_length = held.payload_length;
  assign parsed.is_compound    = held.is_compound;
  assign parsed.packet_end     = held.packet_end;

endmodule

`default_nettype wire

// ----- rtl/core/g2_packet_deframer.sv -----
// Packet deframer for a tagged byte stream.
// The raw channel takes one stream byte per beat. Each accepted byte yields
// exactly one beat on the parsed channel, carrying the byte, its class
// (control, length, name, payload, stream end or rejected big-endian control
// byte), its place within the length or name field, the name length, the
// payload length gathered so far, the compound flag and a last-byte mark.
// An accepted byte is registered and offered on the parsed channel in the
// cycle after. Throughput is one byte per cycle while beats are taken, set
// by the single result register behind the parsing logic.
// The raw channel stays ready while the result register is empty or its beat
// is taken in the same cycle, so a stalled receiver holds the result and
// stops the raw channel for as long as it stalls, with nothing lost.
// Synchronous reset empties the result register and returns the parser to
// waiting for a control byte, with a name length of one, a payload length of
// zero and the compound flag clear.
`timescale 1ns / 1ps
`default_nettype none

module g2_packet_deframer (
  input  wire logic    clk,
  input  wire logic    rst,
  g2d_raw_if.sink      raw,
  g2d_parsed_if.source parsed
);

  logic             space;
  logic             accept;
  g2d_pkg::result_t result;

  assign raw.ready = space;
  assign accept    = raw.valid && space;

  g2d_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .data_byte (raw.data_byte),
    .result    (result)
  );

  g2d_out_stage u_out_stage (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .result (result),
    .space  (space),
    .parsed (parsed)
  );

endmodule

`default_nettype wire
